[src/sdls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdls_pkg: slot disc loader sequencer package
// Shared codes, register defaults and the state, config and result structs.
// ----------------------------------------------------------------------------
package sdls_pkg;

    localparam int unsigned CMD_W   = 3;
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned MSG_W   = 3;
    localparam int unsigned PZ_W    = 3;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    // host commands
    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FORCE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REINIT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PWR_ACK = 3'd4;

    // disc status
    localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_LOADING   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EJECTING  = 3'd3;
    localparam logic [STAT_W-1:0] ST_WAIT_TAKE = 3'd4;

    // host messages
    localparam logic [MSG_W-1:0] MSG_NONE       = 3'd0;
    localparam logic [MSG_W-1:0] MSG_PWR_REQ    = 3'd1;
    localparam logic [MSG_W-1:0] MSG_LOADED     = 3'd2;
    localparam logic [MSG_W-1:0] MSG_INS_LOADED = 3'd3;
    localparam logic [MSG_W-1:0] MSG_EJECTED    = 3'd4;
    localparam logic [MSG_W-1:0] MSG_FORCED     = 3'd5;

    // pause requests
    localparam logic [PZ_W-1:0] PZ_NONE      = 3'd0;
    localparam logic [PZ_W-1:0] PZ_WAIT      = 3'd1;
    localparam logic [PZ_W-1:0] PZ_WAIT_1000 = 3'd2;
    localparam logic [PZ_W-1:0] PZ_DLY_20    = 3'd3;
    localparam logic [PZ_W-1:0] PZ_DLY_100   = 3'd4;
    localparam logic [PZ_W-1:0] PZ_DLY_1000  = 3'd5;
    localparam logic [PZ_W-1:0] PZ_DLY_5000  = 3'd6;

    // sequence steps
    localparam logic [STEP_W-1:0] STEP_START     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_WAIT_DISC = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LOAD_REQ  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_LOAD_ACK  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_LOADING   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_EJ_REQ    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_EJ_ACK    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_EJECTING  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_TAKEAWAY  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_FORCE_REQ = 4'd9;
    localparam logic [STEP_W-1:0] STEP_FORCE_ACK = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FORCE_END = 4'd11;

    // motor pins: bit 0 in, bit 1 out
    localparam logic [1:0] MOTOR_STOP = 2'b00;
    localparam logic [1:0] MOTOR_IN   = 2'b01;
    localparam logic [1:0] MOTOR_OUT  = 2'b10;

    // configuration register indexes and defaults
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_TO     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EJECT_TO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAKEAWAY_TO = 2'd2;

    localparam logic [CFG_W-1:0] LOAD_TO_RST     = 8'd200;
    localparam logic [CFG_W-1:0] EJECT_TO_RST    = 8'd200;
    localparam logic [CFG_W-1:0] TAKEAWAY_TO_RST = 8'd80;

    typedef struct packed {
        logic [STEP_W-1:0] seq_step;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  wait_count;
        logic              user_ins;
        logic [1:0]        motor;
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] load_to;
        logic [CFG_W-1:0] eject_to;
        logic [CFG_W-1:0] takeaway_to;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        motor;
        logic [STAT_W-1:0] status;
        logic [MSG_W-1:0]  msg;
        logic [PZ_W-1:0]   pause;
    } t_result;

endpackage
`default_nettype wire

[src/sdls_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sdls_step: one sequencer activation
// Applies the host command, then runs one step of the load/eject sequence.
// ----------------------------------------------------------------------------
module sdls_step (
    input  var sdls_pkg::t_state                 i_state,
    input  var sdls_pkg::t_cfg                   i_cfg,
    input  wire logic [sdls_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic                            i_slot,
    input  wire logic                            i_out_end,
    input  wire logic                            i_loaded,
    output sdls_pkg::t_state                     o_state,
    output sdls_pkg::t_result                    o_result
);

    logic [sdls_pkg::STEP_W-1:0] step;
    logic [sdls_pkg::CNT_W-1:0]  wc_inc;
    logic [sdls_pkg::MSG_W-1:0]  msg;
    logic [sdls_pkg::PZ_W-1:0]   pause;
    sdls_pkg::t_state            ns;

    assign wc_inc = i_state.wait_count + 8'd1;

    // command overrides the step
    always_comb begin
        step = i_state.seq_step;
        if (i_cmd == sdls_pkg::CMD_OPEN) begin
            if (i_state.status == sdls_pkg::ST_WAIT_TAKE) begin
                step = sdls_pkg::STEP_LOAD_REQ;
            end else if (i_state.status == sdls_pkg::ST_PRESENT) begin
                step = sdls_pkg::STEP_EJ_REQ;
            end
        end else if (i_cmd == sdls_pkg::CMD_FORCE) begin
            step = sdls_pkg::STEP_FORCE_REQ;
        end else if (i_cmd == sdls_pkg::CMD_REINIT) begin
            step = sdls_pkg::STEP_START;
        end
    end

    always_comb begin
        ns          = i_state;
        ns.seq_step = step;
        msg         = sdls_pkg::MSG_NONE;
        pause       = sdls_pkg::PZ_NONE;
        unique case (step)
            sdls_pkg::STEP_START: begin
                ns.motor  = sdls_pkg::MOTOR_STOP;
                ns.status = sdls_pkg::ST_ABSENT;
                if (i_loaded) begin
                    ns.status = sdls_pkg::ST_PRESENT;
                    pause     = sdls_pkg::PZ_WAIT;
                end else if (i_slot) begin
                    ns.seq_step = sdls_pkg::STEP_LOAD_REQ;
                end else begin
                    ns.seq_step = sdls_pkg::STEP_WAIT_DISC;
                end
            end
            sdls_pkg::STEP_WAIT_DISC: begin
                if (i_slot) begin
                    ns.seq_step = sdls_pkg::STEP_LOAD_REQ;
                end else begin
                    pause       = sdls_pkg::PZ_DLY_20;
                    ns.status   = sdls_pkg::ST_ABSENT;
                    ns.user_ins = 1'b1;
                end
            end
            sdls_pkg::STEP_LOAD_REQ, sdls_pkg::STEP_EJ_REQ,
            sdls_pkg::STEP_FORCE_REQ: begin
                msg         = sdls_pkg::MSG_PWR_REQ;
                pause       = sdls_pkg::PZ_WAIT_1000;
                ns.seq_step = step + 4'd1;
            end
            sdls_pkg::STEP_LOAD_ACK: begin
                if (i_cmd == sdls_pkg::CMD_PWR_ACK) begin
                    ns.motor    = sdls_pkg::MOTOR_IN;
                    ns.seq_step = sdls_pkg::STEP_LOADING;
                    ns.status   = sdls_pkg::ST_LOADING;
                end else begin
                    ns.seq_step = sdls_pkg::STEP_WAIT_DISC;
                    pause       = sdls_pkg::PZ_DLY_1000;
                end
            end
            sdls_pkg::STEP_LOADING: begin
                if (i_loaded) begin
                    ns.wait_count = '0;
                    ns.motor      = sdls_pkg::MOTOR_STOP;
                    msg           = sdls_pkg::MSG_LOADED;
                    if (i_state.user_ins) begin
                        ns.user_ins = 1'b0;
                        msg         = sdls_pkg::MSG_INS_LOADED;
                    end
                    ns.status = sdls_pkg::ST_PRESENT;
                    pause     = sdls_pkg::PZ_WAIT;
                end else begin
                    if (!i_slot) begin
                        ns.wait_count = '0;
                        ns.seq_step   = sdls_pkg::STEP_START;
                    end else if (wc_inc == i_cfg.load_to) begin
                        ns.motor      = sdls_pkg::MOTOR_STOP;
                        ns.seq_step   = sdls_pkg::STEP_TAKEAWAY;
                        ns.wait_count = '0;
                    end else begin
                        ns.wait_count = wc_inc;
                    end
                    pause = sdls_pkg::PZ_DLY_20;
                end
            end
            sdls_pkg::STEP_EJ_ACK: begin
                if (i_cmd == sdls_pkg::CMD_PWR_ACK) begin
                    ns.motor    = sdls_pkg::MOTOR_OUT;
                    ns.seq_step = sdls_pkg::STEP_EJECTING;
                    ns.status   = sdls_pkg::ST_EJECTING;
                end else begin
                    ns.seq_step = sdls_pkg::STEP_EJ_REQ;
                    pause       = sdls_pkg::PZ_DLY_1000;
                end
            end
            sdls_pkg::STEP_EJECTING: begin
                if (i_out_end) begin
                    ns.wait_count = '0;
                    ns.motor      = sdls_pkg::MOTOR_STOP;
                    ns.seq_step   = sdls_pkg::STEP_TAKEAWAY;
                    ns.status     = sdls_pkg::ST_WAIT_TAKE;
                    msg           = sdls_pkg::MSG_EJECTED;
                end else if (wc_inc > i_cfg.eject_to) begin
                    ns.wait_count = '0;
                    ns.motor      = sdls_pkg::MOTOR_STOP;
                    ns.seq_step   = sdls_pkg::STEP_START;
                    ns.status     = sdls_pkg::ST_WAIT_TAKE;
                    msg           = sdls_pkg::MSG_EJECTED;
                end else begin
                    ns.wait_count = wc_inc;
                    pause         = sdls_pkg::PZ_DLY_20;
                end
            end
            sdls_pkg::STEP_TAKEAWAY: begin
                if (!i_slot) begin
                    ns.wait_count = '0;
                    ns.seq_step   = sdls_pkg::STEP_WAIT_DISC;
                end else begin
                    if (wc_inc > i_cfg.takeaway_to) begin
                        ns.wait_count = '0;
                        ns.seq_step   = sdls_pkg::STEP_WAIT_DISC;
                    end else begin
                        ns.wait_count = wc_inc;
                    end
                    pause = sdls_pkg::PZ_DLY_100;
                end
            end
            sdls_pkg::STEP_FORCE_ACK: begin
                if (i_cmd == sdls_pkg::CMD_PWR_ACK) begin
                    ns.motor    = sdls_pkg::MOTOR_OUT;
                    ns.seq_step = sdls_pkg::STEP_FORCE_END;
                    pause       = sdls_pkg::PZ_DLY_5000;
                end else begin
                    ns.seq_step = sdls_pkg::STEP_FORCE_REQ;
                    pause       = sdls_pkg::PZ_DLY_1000;
                end
            end
            sdls_pkg::STEP_FORCE_END: begin
                msg         = sdls_pkg::MSG_FORCED;
                ns.motor    = sdls_pkg::MOTOR_STOP;
                ns.seq_step = sdls_pkg::STEP_START;
            end
            default: begin
                ns.seq_step = sdls_pkg::STEP_START;
            end
        endcase
    end

    assign o_state         = ns;
    assign o_result.motor  = ns.motor;
    assign o_result.status = ns.status;
    assign o_result.msg    = msg;
    assign o_result.pause  = pause;

endmodule
`default_nettype wire

[src/slot_disc_loader_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slot_disc_loader_sequencer: slot-in disc loader control
// Runs one load/eject sequence step per transfer and reports motor pins,
// disc status, host message and pause request.
//
//   channel   dir   handshake                    payload
//   input     in    i_in_valid / o_in_stall      cmd, three sensor levels
//   result    out   o_out_valid / i_out_stall    motor pins, status, msg, pause
//   config    in    i_cfg_we                     i_cfg_idx, i_cfg_data
//
// One transfer per cycle unless stalled; a result follows in the next cycle.
// The step logic sits between the state registers and the result register.
// o_in_stall is high only while a held result is stalled.
// Synchronous active-low reset; transfers are taken straight after reset.
// ----------------------------------------------------------------------------
module slot_disc_loader_sequencer (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sdls_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [sdls_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    output      logic                                o_in_stall,
    input  wire logic [sdls_pkg::CMD_W-1:0]          i_cmd,
    input  wire logic                                i_slot_sensor,
    input  wire logic                                i_eject_end_sensor,
    input  wire logic                                i_loaded_sensor,
    output      logic                                o_out_valid,
    input  wire logic                                i_out_stall,
    output      logic                                o_motor_in,
    output      logic                                o_motor_out,
    output      logic [sdls_pkg::STAT_W-1:0]         o_disc_status,
    output      logic [sdls_pkg::MSG_W-1:0]          o_host_msg,
    output      logic [sdls_pkg::PZ_W-1:0]           o_pause_req
);

    sdls_pkg::t_cfg    r_cfg;
    sdls_pkg::t_state  r_state;
    sdls_pkg::t_state  n_state;
    sdls_pkg::t_result r_result;
    sdls_pkg::t_result n_result;
    logic              r_out_valid;
    logic              accept;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    sdls_step u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_cmd     (i_cmd),
        .i_slot    (i_slot_sensor),
        .i_out_end (~i_eject_end_sensor),
        .i_loaded  (~i_loaded_sensor),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.load_to     <= sdls_pkg::LOAD_TO_RST;
            r_cfg.eject_to    <= sdls_pkg::EJECT_TO_RST;
            r_cfg.takeaway_to <= sdls_pkg::TAKEAWAY_TO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdls_pkg::REG_LOAD_TO:     r_cfg.load_to     <= i_cfg_data;
                sdls_pkg::REG_EJECT_TO:    r_cfg.eject_to    <= i_cfg_data;
                sdls_pkg::REG_TAKEAWAY_TO: r_cfg.takeaway_to <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.seq_step   <= sdls_pkg::STEP_START;
            r_state.status     <= sdls_pkg::ST_ABSENT;
            r_state.wait_count <= '0;
            r_state.user_ins   <= 1'b0;
            r_state.motor      <= sdls_pkg::MOTOR_STOP;
            r_out_valid        <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_motor_in    = r_result.motor[0];
    assign o_motor_out   = r_result.motor[1];
    assign o_disc_status = r_result.status;
    assign o_host_msg    = r_result.msg;
    assign o_pause_req   = r_result.pause;

endmodule
`default_nettype wire

[verif/tb_slot_disc_loader_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_slot_disc_loader_sequencer: self-checking bench for the disc loader
// Sends command and sensor transfers, runs a local copy of the load/eject
// sequence on every accepted transfer and compares each result field by field.
// Covers directed load, eject, take-away and forced-eject flows, counter wrap
// at the timeout extremes, random state-aware traffic under several register
// settings, random sender gaps, receiver stall patterns and a long hold-off.
// ----------------------------------------------------------------------------
module tb_slot_disc_loader_sequencer;

    localparam logic [sdls_pkg::CMD_W-1:0] CMD_OTHER  = 3'd5;
    localparam logic [sdls_pkg::CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [sdls_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int WDOG_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 120;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_ITEMS  = 170;

    typedef enum logic [1:0] {RX_READY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                           i_clk              = 1'b0;
    logic                           i_rst_n            = 1'b0;
    logic                           i_cfg_we           = 1'b0;
    logic [sdls_pkg::CFG_IDX_W-1:0] i_cfg_idx          = sdls_pkg::REG_LOAD_TO;
    logic [sdls_pkg::CFG_W-1:0]     i_cfg_data         = '0;
    logic                           i_in_valid         = 1'b0;
    logic                           o_in_stall;
    logic [sdls_pkg::CMD_W-1:0]     i_cmd              = sdls_pkg::CMD_NONE;
    logic                           i_slot_sensor      = 1'b0;
    logic                           i_eject_end_sensor = 1'b1;
    logic                           i_loaded_sensor    = 1'b1;
    logic                           o_out_valid;
    logic                           i_out_stall        = 1'b0;
    logic                           o_motor_in;
    logic                           o_motor_out;
    logic [sdls_pkg::STAT_W-1:0]    o_disc_status;
    logic [sdls_pkg::MSG_W-1:0]     o_host_msg;
    logic [sdls_pkg::PZ_W-1:0]      o_pause_req;

    // loader model state and registers
    logic [sdls_pkg::STEP_W-1:0] st_step     = sdls_pkg::STEP_START;
    logic [sdls_pkg::STAT_W-1:0] st_status   = sdls_pkg::ST_ABSENT;
    logic [sdls_pkg::CNT_W-1:0]  st_count    = '0;
    logic                        st_user_ins = 1'b0;
    logic [1:0]                  st_motor    = sdls_pkg::MOTOR_STOP;
    sdls_pkg::t_cfg              timeouts    = '{sdls_pkg::LOAD_TO_RST,
                                                 sdls_pkg::EJECT_TO_RST,
                                                 sdls_pkg::TAKEAWAY_TO_RST};

    sdls_pkg::t_result pending_results[$];
    sdls_pkg::t_result exp_res;
    int       n_sent       = 0;
    int       n_checked    = 0;
    int       n_fail       = 0;
    int       n_settings   = 0;
    int       idle_cycles  = 0;
    int       burst_left   = 0;
    bit       no_gaps      = 1'b0;
    bit       moved;
    bit       hold_request = 1'b0;
    int       hold_left    = 0;
    int       mode_left    = 0;
    t_rx_mode rx_mode      = RX_READY;

    slot_disc_loader_sequencer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_cmd              (i_cmd),
        .i_slot_sensor      (i_slot_sensor),
        .i_eject_end_sensor (i_eject_end_sensor),
        .i_loaded_sensor    (i_loaded_sensor),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_motor_in         (o_motor_in),
        .o_motor_out        (o_motor_out),
        .o_disc_status      (o_disc_status),
        .o_host_msg         (o_host_msg),
        .o_pause_req        (o_pause_req)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // one activation of the loader sequence
    function automatic sdls_pkg::t_result advance_loader(
        logic [sdls_pkg::CMD_W-1:0] cmd, logic slot, logic eject_raw, logic loaded_raw);
        sdls_pkg::t_result res;
        logic              out_end;
        logic              in_place;
        out_end   = !eject_raw;
        in_place  = !loaded_raw;
        res.msg   = sdls_pkg::MSG_NONE;
        res.pause = sdls_pkg::PZ_NONE;

        if (cmd == sdls_pkg::CMD_OPEN) begin
            if (st_status == sdls_pkg::ST_WAIT_TAKE) begin
                st_step = sdls_pkg::STEP_LOAD_REQ;
            end else if (st_status == sdls_pkg::ST_PRESENT) begin
                st_step = sdls_pkg::STEP_EJ_REQ;
            end
        end else if (cmd == sdls_pkg::CMD_FORCE) begin
            st_step = sdls_pkg::STEP_FORCE_REQ;
        end else if (cmd == sdls_pkg::CMD_REINIT) begin
            st_step = sdls_pkg::STEP_START;
        end

        case (st_step)
            sdls_pkg::STEP_START: begin
                st_motor  = sdls_pkg::MOTOR_STOP;
                st_status = sdls_pkg::ST_ABSENT;
                if (in_place) begin
                    st_status = sdls_pkg::ST_PRESENT;
                    res.pause = sdls_pkg::PZ_WAIT;
                end else if (slot) begin
                    st_step = sdls_pkg::STEP_LOAD_REQ;
                end else begin
                    st_step = sdls_pkg::STEP_WAIT_DISC;
                end
            end
            sdls_pkg::STEP_WAIT_DISC: begin
                if (slot) begin
                    st_step = sdls_pkg::STEP_LOAD_REQ;
                end else begin
                    res.pause   = sdls_pkg::PZ_DLY_20;
                    st_status   = sdls_pkg::ST_ABSENT;
                    st_user_ins = 1'b1;
                end
            end
            sdls_pkg::STEP_LOAD_REQ, sdls_pkg::STEP_EJ_REQ,
            sdls_pkg::STEP_FORCE_REQ: begin
                res.msg   = sdls_pkg::MSG_PWR_REQ;
                res.pause = sdls_pkg::PZ_WAIT_1000;
                st_step   = st_step + 1'b1;
            end
            sdls_pkg::STEP_LOAD_ACK: begin
                if (cmd == sdls_pkg::CMD_PWR_ACK) begin
                    st_motor  = sdls_pkg::MOTOR_IN;
                    st_step   = sdls_pkg::STEP_LOADING;
                    st_status = sdls_pkg::ST_LOADING;
                end else begin
                    st_step   = sdls_pkg::STEP_WAIT_DISC;
                    res.pause = sdls_pkg::PZ_DLY_1000;
                end
            end
            sdls_pkg::STEP_LOADING: begin
                if (in_place) begin
                    st_count  = '0;
                    st_motor  = sdls_pkg::MOTOR_STOP;
                    res.msg   = sdls_pkg::MSG_LOADED;
                    if (st_user_ins) begin
                        st_user_ins = 1'b0;
                        res.msg     = sdls_pkg::MSG_INS_LOADED;
                    end
                    st_status = sdls_pkg::ST_PRESENT;
                    res.pause = sdls_pkg::PZ_WAIT;
                end else begin
                    if (!slot) begin
                        st_count = '0;
                        st_step  = sdls_pkg::STEP_START;
                    end else begin
                        st_count = st_count + 1'b1;
                        if (st_count == timeouts.load_to) begin
                            st_motor = sdls_pkg::MOTOR_STOP;
                            st_step  = sdls_pkg::STEP_TAKEAWAY;
                            st_count = '0;
                        end
                    end
                    res.pause = sdls_pkg::PZ_DLY_20;
                end
            end
            sdls_pkg::STEP_EJ_ACK: begin
                if (cmd == sdls_pkg::CMD_PWR_ACK) begin
                    st_motor  = sdls_pkg::MOTOR_OUT;
                    st_step   = sdls_pkg::STEP_EJECTING;
                    st_status = sdls_pkg::ST_EJECTING;
                end else begin
                    st_step   = sdls_pkg::STEP_EJ_REQ;
                    res.pause = sdls_pkg::PZ_DLY_1000;
                end
            end
            sdls_pkg::STEP_EJECTING: begin
                if (out_end) begin
                    st_count  = '0;
                    st_motor  = sdls_pkg::MOTOR_STOP;
                    st_step   = sdls_pkg::STEP_TAKEAWAY;
                    st_status = sdls_pkg::ST_WAIT_TAKE;
                    res.msg   = sdls_pkg::MSG_EJECTED;
                end else begin
                    st_count = st_count + 1'b1;
                    if (st_count > timeouts.eject_to) begin
                        st_count  = '0;
                        st_motor  = sdls_pkg::MOTOR_STOP;
                        st_step   = sdls_pkg::STEP_START;
                        st_status = sdls_pkg::ST_WAIT_TAKE;
                        res.msg   = sdls_pkg::MSG_EJECTED;
                    end else begin
                        res.pause = sdls_pkg::PZ_DLY_20;
                    end
                end
            end
            sdls_pkg::STEP_TAKEAWAY: begin
                if (!slot) begin
                    st_count = '0;
                    st_step  = sdls_pkg::STEP_WAIT_DISC;
                end else begin
                    st_count = st_count + 1'b1;
                    if (st_count > timeouts.takeaway_to) begin
                        st_count = '0;
                        st_step  = sdls_pkg::STEP_WAIT_DISC;
                    end
                    res.pause = sdls_pkg::PZ_DLY_100;
                end
            end
            sdls_pkg::STEP_FORCE_ACK: begin
                if (cmd == sdls_pkg::CMD_PWR_ACK) begin
                    st_motor  = sdls_pkg::MOTOR_OUT;
                    st_step   = sdls_pkg::STEP_FORCE_END;
                    res.pause = sdls_pkg::PZ_DLY_5000;
                end else begin
                    st_step   = sdls_pkg::STEP_FORCE_REQ;
                    res.pause = sdls_pkg::PZ_DLY_1000;
                end
            end
            sdls_pkg::STEP_FORCE_END: begin
                res.msg  = sdls_pkg::MSG_FORCED;
                st_motor = sdls_pkg::MOTOR_STOP;
                st_step  = sdls_pkg::STEP_START;
            end
            default: begin
                st_step = sdls_pkg::STEP_START;
            end
        endcase

        res.motor  = st_motor;
        res.status = st_status;
        return res;
    endfunction

    // transfer monitor, result check and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS) begin
                        $display("%0t: unexpected result motor=%b%b status=%0d msg=%0d pause=%0d",
                                 $time, o_motor_out, o_motor_in, o_disc_status, o_host_msg,
                                 o_pause_req);
                    end
                end else begin
                    exp_res = pending_results.pop_front();
                    n_checked++;
                    if (o_motor_in !== exp_res.motor[0] || o_motor_out !== exp_res.motor[1]
                        || o_disc_status !== exp_res.status || o_host_msg !== exp_res.msg
                        || o_pause_req !== exp_res.pause) begin
                        n_fail++;
                        if (n_fail <= MAX_REPORTS) begin
                            $display("%0t: result %0d exp motor=%b status=%0d msg=%0d pause=%0d",
                                     $time, n_checked, exp_res.motor, exp_res.status,
                                     exp_res.msg, exp_res.pause);
                            $display("%0t: result %0d got motor=%b%b status=%0d msg=%0d pause=%0d",
                                     $time, n_checked, o_motor_out, o_motor_in, o_disc_status,
                                     o_host_msg, o_pause_req);
                        end
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                pending_results.push_back(advance_loader(i_cmd, i_slot_sensor,
                                                         i_eject_end_sensor, i_loaded_sensor));
                n_sent++;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sdls_pkg::REG_LOAD_TO:     timeouts.load_to     = i_cfg_data;
                    sdls_pkg::REG_EJECT_TO:    timeouts.eject_to    = i_cfg_data;
                    sdls_pkg::REG_TAKEAWAY_TO: timeouts.takeaway_to = i_cfg_data;
                    default: ;
                endcase
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results pending",
                         idle_cycles, pending_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver stall patterns with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 200);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_READY:    i_out_stall <= 1'b0;
                RX_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: i_out_stall <= mode_left[2];
                default:     i_out_stall <= 1'b0;
            endcase
        end
    end

    // offer one transfer and hold it until accepted; returns at a falling edge
    task automatic send_item(input logic [sdls_pkg::CMD_W-1:0] cmd, input logic slot,
                             input logic eject_raw, input logic loaded_raw);
        int gap;
        int sent_before;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_cmd              <= cmd;
        i_slot_sensor      <= slot;
        i_eject_end_sensor <= eject_raw;
        i_loaded_sensor    <= loaded_raw;
        i_in_valid         <= 1'b1;
        sent_before = n_sent;
        do @(negedge i_clk); while (n_sent == sent_before);
    endtask

    // mostly plausible sensor and command traffic for the current step
    task automatic send_random_transfer();
        logic [sdls_pkg::CMD_W-1:0] cmd;
        logic                       slot;
        logic                       eject_raw;
        logic                       loaded_raw;
        int                         pick;
        if ($urandom_range(0, 99) < 6) begin
            pick       = $urandom_range(0, 7);
            cmd        = pick[sdls_pkg::CMD_W-1:0];
            slot       = ($urandom_range(0, 1) == 1);
            eject_raw  = ($urandom_range(0, 1) == 1);
            loaded_raw = ($urandom_range(0, 1) == 1);
        end else begin
            cmd = sdls_pkg::CMD_NONE;
            if (st_step == sdls_pkg::STEP_LOAD_ACK || st_step == sdls_pkg::STEP_EJ_ACK
                || st_step == sdls_pkg::STEP_FORCE_ACK) begin
                if ($urandom_range(0, 99) < 85) begin
                    cmd = sdls_pkg::CMD_PWR_ACK;
                end
            end else if ((st_status == sdls_pkg::ST_PRESENT
                          || st_status == sdls_pkg::ST_WAIT_TAKE)
                         && $urandom_range(0, 99) < 10) begin
                cmd = sdls_pkg::CMD_OPEN;
            end else if ($urandom_range(0, 99) < 3) begin
                cmd = sdls_pkg::CMD_FORCE;
            end else if ($urandom_range(0, 99) < 2) begin
                cmd = sdls_pkg::CMD_REINIT;
            end
            if (st_step == sdls_pkg::STEP_LOADING || st_step == sdls_pkg::STEP_TAKEAWAY) begin
                slot = ($urandom_range(0, 9) != 0);
            end else begin
                slot = ($urandom_range(0, 1) == 1);
            end
            if (st_step == sdls_pkg::STEP_LOADING) begin
                loaded_raw = ($urandom_range(0, 99) >= 15);
            end else if (st_step == sdls_pkg::STEP_START) begin
                loaded_raw = ($urandom_range(0, 99) >= 30);
            end else begin
                loaded_raw = ($urandom_range(0, 1) == 1);
            end
            if (st_step == sdls_pkg::STEP_EJECTING) begin
                eject_raw = ($urandom_range(0, 99) >= 20);
            end else begin
                eject_raw = ($urandom_range(0, 1) == 1);
            end
        end
        send_item(cmd, slot, eject_raw, loaded_raw);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_cfg(input logic [sdls_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sdls_pkg::CFG_W-1:0] data);
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_timeouts(input logic [sdls_pkg::CFG_W-1:0] load_to,
                                input logic [sdls_pkg::CFG_W-1:0] eject_to,
                                input logic [sdls_pkg::CFG_W-1:0] takeaway_to);
        wait_drain();
        write_cfg(sdls_pkg::REG_LOAD_TO, load_to);
        write_cfg(sdls_pkg::REG_EJECT_TO, eject_to);
        write_cfg(sdls_pkg::REG_TAKEAWAY_TO, takeaway_to);
        n_settings++;
    endtask

    task automatic test_directed();
        send_item(sdls_pkg::CMD_OPEN,    1'b0, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b0, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b0, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b1);
        send_item(CMD_RSVD_7,            1'b1, 1'b0, 1'b1);
        send_item(sdls_pkg::CMD_PWR_ACK, 1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b0);
        send_item(sdls_pkg::CMD_OPEN,    1'b1, 1'b1, 1'b0);
        send_item(CMD_OTHER,             1'b1, 1'b1, 1'b0);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b0);
        send_item(sdls_pkg::CMD_PWR_ACK, 1'b1, 1'b1, 1'b0);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b0, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b0, 1'b1);
        send_item(sdls_pkg::CMD_OPEN,    1'b1, 1'b0, 1'b1);
        send_item(sdls_pkg::CMD_PWR_ACK, 1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b0);
        send_item(sdls_pkg::CMD_FORCE,   1'b1, 1'b1, 1'b0);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b0);
        send_item(CMD_RSVD_6,            1'b1, 1'b1, 1'b0);
        send_item(sdls_pkg::CMD_PWR_ACK, 1'b1, 1'b1, 1'b0);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_REINIT,  1'b0, 1'b0, 1'b0);
    endtask

    // load timeout of zero fires only after the count wraps
    task automatic test_counter_wrap();
        set_timeouts(8'd0, 8'd255, 8'd0);
        send_item(sdls_pkg::CMD_REINIT,  1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE,    1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_PWR_ACK, 1'b1, 1'b1, 1'b1);
        repeat (262) send_item(sdls_pkg::CMD_NONE, 1'b1, 1'b1, 1'b1);
        send_item(sdls_pkg::CMD_NONE, 1'b0, 1'b1, 1'b1);
    endtask

    // long receiver hold-off while the sender keeps offering, then drain
    task automatic test_backpressure();
        wait_drain();
        no_gaps      = 1'b1;
        burst_left   = 0;
        hold_request = 1'b1;
        repeat (40) send_random_transfer();
        no_gaps = 1'b0;
        wait_drain();
    endtask

    task automatic test_random_settings();
        int pick_load;
        int pick_eject;
        int pick_take;
        set_timeouts(8'd1, 8'd1, 8'd1);
        repeat (PHASE_ITEMS) send_random_transfer();
        set_timeouts(8'd254, 8'd254, 8'd254);
        repeat (PHASE_ITEMS) send_random_transfer();
        repeat (3) begin
            pick_load  = $urandom_range(2, 12);
            pick_eject = $urandom_range(2, 12);
            pick_take  = $urandom_range(2, 12);
            set_timeouts(pick_load[sdls_pkg::CFG_W-1:0], pick_eject[sdls_pkg::CFG_W-1:0],
                         pick_take[sdls_pkg::CFG_W-1:0]);
            repeat (PHASE_ITEMS) send_random_transfer();
        end
        set_timeouts(sdls_pkg::LOAD_TO_RST, sdls_pkg::EJECT_TO_RST,
                     sdls_pkg::TAKEAWAY_TO_RST);
        repeat (PHASE_ITEMS) send_random_transfer();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_counter_wrap();
        test_backpressure();
        test_random_settings();
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            n_fail += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end
        $display("Ran %0d command/sensor transfers under %0d timeout settings (wrap, hold-off).",
                 n_sent, n_settings);
        $display("Checked %0d results, %0d failures.", n_checked, n_fail);
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
src/sdls_pkg.sv
src/sdls_step.sv
src/slot_disc_loader_sequencer.sv
verif/tb_slot_disc_loader_sequencer.sv
